[src/ile_pkg.sv]
// ----------------------------------------------------------------------------
// ile_pkg: shared types and constants of the indexed list engine
// Sizes of the list, field widths, request and result formats, and the
// command that the control logic broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 8;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 2;

  localparam logic [ACT_W-1:0] ACT_READ = 3'd0;
  localparam logic [ACT_W-1:0] ACT_HEAD = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TAIL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_AT   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DEL  = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       count;
  } rsp_t;

  // Command broadcast to every cell in the cycle a request is transferred.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [CMP_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

[src/ile_cell.sv]
// ----------------------------------------------------------------------------
// ile_cell: one storage cell of the list
// Holds the entry at a fixed list position and shifts toward the tail on an
// insert or toward the head on a delete, taking its neighbor's entry.
// ----------------------------------------------------------------------------
module ile_cell
  import ile_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  cmd_t              cmd,
  input  logic [DATA_W-1:0] left,
  input  logic [DATA_W-1:0] right,
  input  logic [CMP_W-1:0]  rd_pos,
  output logic [DATA_W-1:0] entry,
  output logic [DATA_W-1:0] rd_part
);

  logic [CMP_W-1:0] my_pos;

  assign my_pos  = CMP_W'(idx);
  // Only the addressed cell drives its entry onto the shared read bus.
  assign rd_part = (my_pos == rd_pos) ? entry : '0;

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (my_pos > cmd.pos) begin
        entry <= left;
      end else if (my_pos == cmd.pos) begin
        entry <= cmd.value;
      end
    end else if (cmd.del) begin
      if (my_pos >= cmd.pos) begin
        entry <= right;
      end
    end
  end

endmodule

[src/indexed_list_engine.sv]
// ----------------------------------------------------------------------------
// indexed_list_engine: ordered list of signed 32-bit entries
// Reads, inserts and deletes entries by list position in a row of cells.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the req channel (req_valid, req_stall, req) and
// results leave on the rsp channel (rsp_valid, rsp_stall, rsp). Each request
// transfer produces exactly one result transfer, in request order.
// A request holds an action (read, insert at head, insert at tail, insert
// before a position, delete at a position), a position and a value.
// The result carries the read entry (all ones unless a read succeeded), a
// status (done, position invalid, list full) and the count after the request.
// The result is registered at the edge where the request transfer happens.
// Throughput is one request per cycle while the receiver does not stall,
// set by the row of CAPACITY cells, which all compare their own position
// with the request position and shift in parallel.
// When the receiver stalls, the result register holds its result and
// req_stall is raised until that result has been transferred.
// Reset empties the list (count zero) and drops any pending result; the
// cell contents are left as they are, since only positions below the count
// are ever read.
// ----------------------------------------------------------------------------
module indexed_list_engine
  import ile_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic                     accept;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         cnt_next;
  logic [CMP_W-1:0]         pos_c;
  logic [CMP_W-1:0]         cnt_c;
  logic [CMP_W-1:0]         ins_pos;
  logic                     is_ins;
  logic                     full;
  logic                     rd_hit;
  cmd_t                     cmd;
  rsp_t                     rsp_next;
  logic [DATA_W-1:0]        rd_bus;
  logic [DATA_W-1:0]        entries  [CAPACITY];
  logic [DATA_W-1:0]        rd_parts [CAPACITY];

  // A new request can be taken whenever the result register is free or is
  // being emptied in this very cycle.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    pos_c   = CMP_W'(req.position);
    cnt_c   = CMP_W'(cnt);
    full    = (cnt == CNT_W'(CAPACITY));
    is_ins  = (req.action == ACT_HEAD) || (req.action == ACT_TAIL) ||
              (req.action == ACT_AT);
    if (req.action == ACT_HEAD) begin
      ins_pos = '0;
    end else if (req.action == ACT_TAIL) begin
      ins_pos = cnt_c;
    end else begin
      ins_pos = pos_c;
    end
    rd_hit = 1'b0;

    cmd.ins   = 1'b0;
    cmd.del   = 1'b0;
    cmd.pos   = is_ins ? ins_pos : pos_c;
    cmd.value = req.value;
    cnt_next  = cnt;
    rsp_next.status = ST_DONE;

    case (req.action)
      ACT_READ: begin
        if (pos_c < cnt_c) begin
          rd_hit = 1'b1;
        end else begin
          rsp_next.status = ST_BADPOS;
        end
      end
      ACT_HEAD, ACT_TAIL, ACT_AT: begin
        // The position check takes priority over the full check.
        if (ins_pos > cnt_c) begin
          rsp_next.status = ST_BADPOS;
        end else if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          cmd.ins  = accept;
          cnt_next = cnt + 1'b1;
        end
      end
      ACT_DEL: begin
        if (pos_c < cnt_c) begin
          cmd.del  = accept;
          cnt_next = cnt - 1'b1;
        end else begin
          rsp_next.status = ST_BADPOS;
        end
      end
      default: begin
        rsp_next.status = ST_BADPOS;
      end
    endcase

    rsp_next.read_value = rd_hit ? rd_bus : '1;
    rsp_next.count      = COUNT_W'(cnt_next);
  end

  // Row of cells. Each cell takes its left neighbor's entry on an insert and
  // its right neighbor's entry on a delete. The head cell's left input is
  // never selected, and the tail cell simply keeps its own entry on a delete.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;

    if (i == 0) begin : g_head
      assign left_in = req.value;
    end else begin : g_mid_l
      assign left_in = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_in = entries[i];
    end else begin : g_mid_r
      assign right_in = entries[i+1];
    end

    ile_cell u_cell (
      .clk     (clk),
      .idx     (IDX_W'(i)),
      .cmd     (cmd),
      .left    (left_in),
      .right   (right_in),
      .rd_pos  (pos_c),
      .entry   (entries[i]),
      .rd_part (rd_parts[i])
    );
  end

  // At most one cell drives a nonzero word, so an OR merges the read bus.
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus = rd_bus | rd_parts[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

[src/ile_checker.sv]
// ----------------------------------------------------------------------------
// ile_checker: port-level checks of the indexed list engine
// Watches the request and result channels and flags inconsistent results.
// ----------------------------------------------------------------------------
module ile_checker
  import ile_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // A stalled request must stay up and unchanged until it is transferred.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("request changed while stalled");

  // A stalled result must not change until it is transferred.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // The block only stalls requests while a result is waiting.
  assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a waiting result");

  // Any refused request reports the all-ones read word.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_DONE) |-> rsp.read_value == '1)
    else $error("refused request carries read data");

  // A full refusal only happens when the list holds its whole capacity.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> rsp.count == COUNT_W'(CAPACITY))
    else $error("full status with a list that is not full");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
